### sv/sha1e_pkg.sv
// Package for the SHA-1 hash engine: constants, round tables and shared types.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
`default_nettype none
package sha1e_pkg;

    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int NUM_WORDS  = 5;
    localparam int BLK_WORDS  = 16;
    localparam int BLK_BITS   = BLK_WORDS * WORD_W;
    localparam int POS_W      = 6;
    localparam int ROUND_W    = 7;
    localparam int CNT_W      = 64;

    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
    localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;
    localparam logic [BYTE_W-1:0]  PAD_MARK   = 8'h80;
    localparam logic [CNT_W-1:0]   CNT_STEP   = 64'd8;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_chain;

    localparam t_chain INIT_H = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef struct packed {
        logic               init;
        logic               step;
        logic [ROUND_W-1:0] idx;
    } t_round_ctl;

    function automatic t_word round_k(input logic [ROUND_W-1:0] idx);
        t_word k;
        if (idx < 7'd20) begin
            k = 32'h5A827999;
        end else if (idx < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (idx < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    function automatic t_word round_f(input logic [ROUND_W-1:0] idx,
                                      input t_word b, input t_word c, input t_word d);
        t_word f;
        if (idx < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (idx < 7'd40) begin
            f = b ^ c ^ d;
        end else if (idx < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

### sv/sha1e_if.sv
// Channel interfaces of the SHA-1 hash engine: message input and digest output.
// Depends on sha1e_pkg for field widths.
`default_nettype none
interface sha1e_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [sha1e_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha1e_out_if;
    logic                 valid;
    logic                 ready;
    sha1e_pkg::t_word     digest_word0;
    sha1e_pkg::t_word     digest_word1;
    sha1e_pkg::t_word     digest_word2;
    sha1e_pkg::t_word     digest_word3;
    sha1e_pkg::t_word     digest_word4;
    logic                 error_flag;

    modport source (output valid, output digest_word0, output digest_word1,
                    output digest_word2, output digest_word3, output digest_word4,
                    output error_flag, input ready);
    modport sink   (input valid, input digest_word0, input digest_word1,
                    input digest_word2, input digest_word3, input digest_word4,
                    input error_flag, output ready);
endinterface
`default_nettype wire

### sv/sha1e_round.sv
// SHA-1 round unit: working registers a..e and one compression round per step.
// Depends on sha1e_pkg for the round functions, constants and control struct.
`default_nettype none
module sha1e_round (
    input  wire logic                  i_clk,
    input  wire sha1e_pkg::t_round_ctl i_ctl,
    input  wire sha1e_pkg::t_chain     i_chain,
    input  wire sha1e_pkg::t_word      i_w,
    output      sha1e_pkg::t_chain     o_work
);

    sha1e_pkg::t_chain r_work;
    sha1e_pkg::t_chain n_work;
    sha1e_pkg::t_word  temp;

    always_comb begin
        temp = {r_work[0][26:0], r_work[0][31:27]}
             + sha1e_pkg::round_f(i_ctl.idx, r_work[1], r_work[2], r_work[3])
             + r_work[4] + i_w + sha1e_pkg::round_k(i_ctl.idx);
        n_work = r_work;
        if (i_ctl.init) begin
            n_work = i_chain;
        end else if (i_ctl.step) begin
            n_work[4] = r_work[3];
            n_work[3] = r_work[2];
            n_work[2] = {r_work[1][1:0], r_work[1][31:2]};
            n_work[1] = r_work[0];
            n_work[0] = temp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
    end

    assign o_work = r_work;

endmodule
`default_nettype wire

### sv/sha1_hash_engine_core.sv
// SHA-1 hash engine top level: byte intake, padding sequencer and chaining value.
// Depends on sha1e_pkg, sha1e_if (channel interfaces) and sha1e_round.
//
// Usage. Message bytes enter on i_in, one beat per byte with opcode absorb;
// a beat with opcode finish closes the message. Each finish produces one beat
// on o_out carrying the five digest words (word0 holds the first digest byte
// in its top bits) and error_flag. Absorbs produce nothing.
// The 64th byte of a block starts compression: the single round unit runs its
// rounds, then a fold step adds the result into the chaining value; the input
// is held off (ready low) until the fold is done, so no byte is taken while a
// block compresses. A finish feeds the marker, zero fill and length through
// the same byte path, one byte per cycle outside the rounds, then compresses
// one or two blocks and gives its result beat. When the 64-bit bit count has
// overflowed, a finish skips padding and compression and goes straight to
// its result beat (all-zero digest, error_flag set).
// Absorbs are still taken while a digest beat waits on o_out; a later finish
// holds its result until the receiver takes the pending beat.
// Reset (synchronous, active low) clears the message state and loads the
// initial hash words; every finish returns the block to that same state.
`default_nettype none
module sha1_hash_engine_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sha1e_in_if.sink    i_in,
    sha1e_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_FIN
    } t_state;

    t_state                               r_state,     n_state;
    sha1e_pkg::t_chain                    r_chain,     n_chain;
    logic [sha1e_pkg::CNT_W-1:0]          r_cnt,       n_cnt;
    logic [sha1e_pkg::POS_W-1:0]          r_pos,       n_pos;
    logic                                 r_mark,      n_mark;
    logic                                 r_mark_done, n_mark_done;
    logic                                 r_len,       n_len;
    logic [sha1e_pkg::ROUND_W-1:0]        r_round,     n_round;
    logic                                 r_out_valid, n_out_valid;
    logic [sha1e_pkg::BLK_BITS-1:0]       r_blk,       n_blk;
    sha1e_pkg::t_chain                    r_dig,       n_dig;
    logic                                 r_err,       n_err;

    sha1e_pkg::t_round_ctl                round_ctl;
    sha1e_pkg::t_chain                    work;
    logic                                 wr_en;
    logic [sha1e_pkg::BYTE_W-1:0]         wr_byte;
    logic [sha1e_pkg::CNT_W-1:0]          cnt_inc;
    logic [sha1e_pkg::CNT_W-1:0]          len_shift;
    sha1e_pkg::t_word                     sched_mix;
    sha1e_pkg::t_word                     sched_new;

    sha1e_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (round_ctl),
        .i_chain (r_chain),
        .i_w     (r_blk[511:480]),
        .o_work  (work)
    );

    assign cnt_inc   = r_cnt + sha1e_pkg::CNT_STEP;
    assign len_shift = r_cnt << {r_pos[2:0], 3'b000};

    // Schedule window: word j of the window sits at r_blk[511-32j -: 32].
    assign sched_mix = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign sched_new = {sched_mix[30:0], sched_mix[31]};

    always_comb begin
        n_state     = r_state;
        n_chain     = r_chain;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_mark      = r_mark;
        n_mark_done = r_mark_done;
        n_len       = r_len;
        n_round     = r_round;
        n_out_valid = r_out_valid && !o_out.ready;
        n_blk       = r_blk;
        n_dig       = r_dig;
        n_err       = r_err;
        round_ctl   = '0;
        round_ctl.idx = r_round;
        wr_en       = 1'b0;
        wr_byte     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.opcode == sha1e_pkg::OP_ABSORB) begin
                        if (!r_mark) begin
                            wr_en   = 1'b1;
                            wr_byte = i_in.data_byte;
                            n_cnt   = cnt_inc;
                            if (cnt_inc == '0) begin
                                n_mark = 1'b1;
                            end
                        end
                    end else if (r_mark) begin
                        n_state = S_FIN;
                    end else begin
                        n_state     = S_PAD;
                        n_mark_done = 1'b0;
                        n_len       = 1'b0;
                    end
                end
            end
            S_PAD: begin
                wr_en = 1'b1;
                if (!r_mark_done) begin
                    wr_byte     = sha1e_pkg::PAD_MARK;
                    n_mark_done = 1'b1;
                end else if (r_len || r_pos == sha1e_pkg::POS_LEN) begin
                    // Length field, most significant byte first.
                    wr_byte = len_shift[63:56];
                    n_len   = 1'b1;
                end else begin
                    wr_byte = '0;
                end
            end
            S_ROUND: begin
                round_ctl.step = 1'b1;
                n_blk = {r_blk[479:0], sched_new};
                if (r_round == sha1e_pkg::ROUND_LAST) begin
                    n_round = '0;
                    n_state = S_FOLD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < sha1e_pkg::NUM_WORDS; i++) begin
                    n_chain[i] = r_chain[i] + work[i];
                end
                if (!r_mark_done) begin
                    n_state = S_IDLE;
                end else if (r_len) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_err       = r_mark;
                    n_dig       = r_mark ? '0 : r_chain;
                    n_chain     = sha1e_pkg::INIT_H;
                    n_cnt       = '0;
                    n_pos       = '0;
                    n_mark      = 1'b0;
                    n_mark_done = 1'b0;
                    n_len       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (wr_en) begin
            n_blk = {r_blk[503:0], wr_byte};
            n_pos = r_pos + 1'b1;
            if (r_pos == sha1e_pkg::POS_LAST) begin
                n_state        = S_ROUND;
                round_ctl.init = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_dig <= n_dig;
        r_err <= n_err;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chain     <= sha1e_pkg::INIT_H;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_mark      <= 1'b0;
            r_mark_done <= 1'b0;
            r_len       <= 1'b0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_mark      <= n_mark;
            r_mark_done <= n_mark_done;
            r_len       <= n_len;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.digest_word0 = r_dig[0];
    assign o_out.digest_word1 = r_dig[1];
    assign o_out.digest_word2 = r_dig[2];
    assign o_out.digest_word3 = r_dig[3];
    assign o_out.digest_word4 = r_dig[4];
    assign o_out.error_flag   = r_err;

    // A block is compressed only once all 64 of its bytes are in.
    a_pos_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_pos == '0))
        else $error("byte position not at block start during rounds");

    // Once the bit count has wrapped, no byte may advance it again.
    a_mark_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark |-> (r_cnt == '0))
        else $error("bit count moved after overflow");

    // The round counter runs only inside the round phase.
    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == '0))
        else $error("round counter active outside rounds");

    // The last round is always followed by the fold into the chaining value.
    a_last_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == sha1e_pkg::ROUND_LAST) |=> (r_state == S_FOLD))
        else $error("fold did not follow the last round");

    // An overflowed message reports an all-zero digest.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err) |-> (r_dig == '0))
        else $error("error beat carries a nonzero digest");

endmodule
`default_nettype wire

### sim/tb_sha1_hash_engine_core.sv
// Self-checking testbench for sha1_hash_engine_core: directed rows, a receiver hold-off, then random messages.
// Depends on sha1e_pkg, sha1e_if and the engine RTL; a digest predictor runs inside the bench.
module tb_sha1_hash_engine_core;
    import sha1e_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int HOLD_CYCLES    = 1200;
    // At the end, wait past the longest time a finish can take to produce its beat.
    localparam int TAIL_CYCLES    = 300;
    // The long receiver hold plus a finish latency stays well under this.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 550;
    localparam int RESULT_TARGET  = 40;
    localparam int MAX_PRINTS     = 100;

    localparam t_word K_ROUND0 = 32'h5A827999;
    localparam t_word K_ROUND1 = 32'h6ED9EBA1;
    localparam t_word K_ROUND2 = 32'h8F1BBCDC;
    localparam t_word K_ROUND3 = 32'hCA62C1D6;

    typedef struct packed {
        t_word word0;
        t_word word1;
        t_word word2;
        t_word word3;
        t_word word4;
        logic  err;
    } digest_t;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic              typed;
        digest_t           want;
    } stim_row_t;

    localparam digest_t DIG_EMPTY = '{32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF,
                                      32'h95601890, 32'hAFD80709, 1'b0};
    localparam digest_t DIG_ABC   = '{32'hA9993E36, 32'h4706816A, 32'hBA3E2571,
                                      32'h7850C26C, 32'h9CD0D89D, 1'b0};
    localparam digest_t DIG_NONE  = '0;

    localparam int STIM_ROWS = 20;
    localparam stim_row_t STIM_TBL [STIM_ROWS] = '{
        '{OP_FINISH, 8'h00, 1'b1, DIG_EMPTY},
        '{OP_ABSORB, 8'h61, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'h62, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'h63, 1'b0, DIG_NONE},
        '{OP_FINISH, 8'hFF, 1'b1, DIG_ABC},
        '{OP_FINISH, 8'h5A, 1'b1, DIG_EMPTY},
        '{OP_ABSORB, 8'h00, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'hFF, 1'b0, DIG_NONE},
        '{OP_FINISH, 8'h00, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'h80, 1'b0, DIG_NONE},
        '{OP_FINISH, 8'h00, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'hFF, 1'b0, DIG_NONE},
        '{OP_FINISH, 8'h00, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'h01, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'h7F, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'hFE, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'h55, 1'b0, DIG_NONE},
        '{OP_ABSORB, 8'hAA, 1'b0, DIG_NONE},
        '{OP_FINISH, 8'h00, 1'b0, DIG_NONE},
        '{OP_FINISH, 8'hA5, 1'b1, DIG_EMPTY}
    };

    // Message lengths that put the pad marker and length field on block boundaries.
    localparam int EDGE_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 128};
    localparam int PHASE_GAP   [4] = '{0, 62, 0, 20};
    localparam int PHASE_STALL [4] = '{0, 0, 62, 20};

    logic i_clk = 1'b0;
    logic i_rst_n;

    sha1e_in_if  in_if ();
    sha1e_out_if out_if ();

    sha1_hash_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Predictor state.
    logic [BYTE_W-1:0] msg_buf [64];
    int                msg_pos;
    t_chain            hash_st;
    logic [CNT_W-1:0]  msg_bits;
    logic              msg_ovf;

    digest_t digest_q [$];

    int errors        = 0;
    int items_taken   = 0;
    int results_due   = 0;
    int digests_seen  = 0;
    int bytes_taken   = 0;
    int cur_len       = 0;
    int longest_msg   = 0;
    int spill_count   = 0;
    int quiet_cycles  = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit row_typed     = 1'b0;
    digest_t row_want = '0;

    function automatic t_word rol32(input t_word x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic void hash_reset();
        for (int i = 0; i < 64; i++) msg_buf[i] = '0;
        msg_pos  = 0;
        hash_st  = INIT_H;
        msg_bits = '0;
        msg_ovf  = 1'b0;
    endfunction

    function automatic void sha1_compress();
        t_word w [80];
        t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = hash_st[0];
        b = hash_st[1];
        c = hash_st[2];
        d = hash_st[3];
        e = hash_st[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            t = rol32(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_st[0] = hash_st[0] + a;
        hash_st[1] = hash_st[1] + b;
        hash_st[2] = hash_st[2] + c;
        hash_st[3] = hash_st[3] + d;
        hash_st[4] = hash_st[4] + e;
        msg_pos = 0;
    endfunction

    // Advances the predictor by one input beat; returns 1 when a digest beat is due.
    function automatic bit hash_step(input logic op, input logic [BYTE_W-1:0] val,
                                     output digest_t res);
        int pos;
        res = '0;
        if (op == OP_ABSORB) begin
            if (msg_ovf) return 1'b0;
            msg_buf[msg_pos & 63] = val;
            msg_pos  = (msg_pos + 1) & 127;
            msg_bits = msg_bits + CNT_STEP;
            // A wrapped bit count poisons the rest of the message.
            if (msg_bits == '0) msg_ovf = 1'b1;
            if (msg_pos >= 64) sha1_compress();
            return 1'b0;
        end
        if (msg_ovf) begin
            res.err = 1'b1;
        end else begin
            pos = msg_pos & 63;
            msg_buf[pos] = PAD_MARK;
            pos++;
            // No room left for the length field, so it goes into an extra block.
            if (pos > int'(POS_LEN)) begin
                while (pos < 64) begin
                    msg_buf[pos] = '0;
                    pos++;
                end
                sha1_compress();
                pos = 0;
            end
            while (pos < int'(POS_LEN)) begin
                msg_buf[pos] = '0;
                pos++;
            end
            for (int i = 0; i < 8; i++) begin
                msg_buf[int'(POS_LEN) + i] = BYTE_W'(msg_bits >> (56 - 8 * i));
            end
            sha1_compress();
            res.word0 = hash_st[0];
            res.word1 = hash_st[1];
            res.word2 = hash_st[2];
            res.word3 = hash_st[3];
            res.word4 = hash_st[4];
        end
        hash_reset();
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("MISMATCH %s: got %08h, expected %08h (digest %0d)",
                     what, got, want, digests_seen);
        end
    endtask

    // Offers one beat from a falling edge and returns at the falling edge after it is taken.
    task automatic offer(input logic op, input logic [BYTE_W-1:0] val);
        while ($urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.opcode    <= op;
        in_if.data_byte <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops offering until every digest that is due has been taken.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold-off when the sender asks for one.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_beats
        digest_t got;
        digest_t want;
        digest_t pred;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.digest_word0, out_if.digest_word1, out_if.digest_word2,
                        out_if.digest_word3, out_if.digest_word4, out_if.error_flag};
                if (digest_q.size() == 0) begin
                    note_mismatch("digest beat with nothing due", got.word0, '0);
                end else begin
                    want = digest_q.pop_front();
                    if (got.word0 !== want.word0) note_mismatch("digest_word0", got.word0, want.word0);
                    if (got.word1 !== want.word1) note_mismatch("digest_word1", got.word1, want.word1);
                    if (got.word2 !== want.word2) note_mismatch("digest_word2", got.word2, want.word2);
                    if (got.word3 !== want.word3) note_mismatch("digest_word3", got.word3, want.word3);
                    if (got.word4 !== want.word4) note_mismatch("digest_word4", got.word4, want.word4);
                    if (got.err !== want.err) begin
                        note_mismatch("error_flag", WORD_W'(got.err), WORD_W'(want.err));
                    end
                    digests_seen++;
                end
            end
            if (in_if.valid && in_if.ready) begin
                items_taken++;
                if (in_if.opcode == OP_ABSORB) begin
                    bytes_taken++;
                    cur_len++;
                end else begin
                    if ((cur_len % 64) >= int'(POS_LEN)) spill_count++;
                    if (cur_len > longest_msg) longest_msg = cur_len;
                    cur_len = 0;
                end
                if (hash_step(in_if.opcode, in_if.data_byte, pred)) begin
                    results_due++;
                    digest_q.push_back(row_typed ? row_want : pred);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d digests outstanding",
                     quiet_cycles, digest_q.size());
            $display("tb_sha1_hash_engine_core: done, errors");
            $finish;
        end
    end

    initial begin
        int len;
        int pick;
        int msg_n;
        int phase;
        hash_reset();
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.opcode    = OP_ABSORB;
        in_if.data_byte = '0;
        out_if.ready    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows: empty message, a known vector, byte extremes, back-to-back finishes.
        for (int r = 0; r < STIM_ROWS; r++) begin
            row_typed = STIM_TBL[r].typed;
            row_want  = STIM_TBL[r].want;
            offer(STIM_TBL[r].op, STIM_TBL[r].data);
        end
        row_typed = 1'b0;
        drain();

        // The receiver holds off while messages keep coming, so a second digest backs up
        // inside the engine and the input stalls behind it.
        hold_req = 1'b1;
        offer(OP_ABSORB, 8'h71);
        offer(OP_FINISH, 8'h00);
        for (int j = 0; j < 70; j++) offer(OP_ABSORB, BYTE_W'($urandom_range(255)));
        offer(OP_FINISH, BYTE_W'($urandom_range(255)));
        for (int j = 0; j < 3; j++) offer(OP_ABSORB, BYTE_W'($urandom_range(255)));
        offer(OP_FINISH, BYTE_W'($urandom_range(255)));
        drain();

        msg_n = 0;
        while (items_taken < ITEM_TARGET || results_due < RESULT_TARGET) begin
            if (msg_n % 6 == 0) begin
                drain();
                phase     = (msg_n / 6) % 4;
                gap_pct   = PHASE_GAP[phase];
                stall_pct = PHASE_STALL[phase];
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(10);
            end else if (pick < 82) begin
                len = EDGE_LENS[$urandom_range(9)];
            end else begin
                len = $urandom_range(40, 11);
            end
            for (int j = 0; j < len; j++) begin
                // Now and then a stray finish cuts the message short.
                if ($urandom_range(99) < 4) begin
                    offer(OP_FINISH, BYTE_W'($urandom_range(255)));
                end else begin
                    offer(OP_ABSORB, BYTE_W'($urandom_range(255)));
                end
            end
            offer(OP_FINISH, BYTE_W'($urandom_range(255)));
            msg_n++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d digests checked, %0d message bytes, longest message %0d bytes",
                 digests_seen, bytes_taken, longest_msg);
        $display("summary: %0d finishes needed a second pad block; %0d random messages ran",
                 spill_count, msg_n);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("tb_sha1_hash_engine_core: done, clean");
        end else begin
            $display("tb_sha1_hash_engine_core: done, errors");
        end
        $finish;
    end

endmodule
